### hdl/rc5_pkg.sv
package rc5_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Magic constants of the 32-bit word variant
  localparam word_t MAGIC_P = 32'hB7E1_5163;
  localparam word_t MAGIC_Q = 32'h9E37_79B9;

  // Fixed rotation in the key schedule
  localparam logic [4:0] KEY_ROT = 5'd3;

  // Defaults for the top-level parameters
  localparam int DEF_ROUNDS        = 12;
  localparam int DEF_MAX_KEY_BYTES = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 5;

  // Rotate left; an amount of zero gives the word back unchanged
  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << n;
    return t[2*WORD_W-1:WORD_W];
  endfunction

endpackage

### hdl/rc5_block_encryptor.sv
// RC5-32 block encryptor. Each input transaction carries one 64-bit plaintext
// block (word_a in tdata[31:0], word_b in tdata[63:32]); each output
// transaction carries the ciphertext pair in the same layout. The round keys
// come from the three configuration registers (key bytes 0-7, key bytes 8-15,
// key length, reset 16 bytes of zero). Any register write restarts the key
// schedule: a fill pass over the table, then three mixing passes with an A
// step and a B step per word; s_tready stays low for that time, and also
// after reset. Once the schedule is done the block takes one block per cycle
// while the output buffer is not full: every half round has its own pipeline
// stage, so an item spends 2*ROUNDS+1 stages in the pipeline before the
// output buffer. A two-entry output buffer lets the pipeline keep moving
// while one result waits for m_tready. Write configuration only with the
// pipeline empty.
module rc5_block_encryptor #(
  parameter int ROUNDS        = rc5_pkg::DEF_ROUNDS,
  parameter int MAX_KEY_BYTES = rc5_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [63:0]                    s_tdata,   // word_a [31:0], word_b [63:32]
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [63:0]                    m_tdata,   // cipher_a [31:0], cipher_b [63:32]
  // configuration write port
  input  logic                           cfg_we,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc5_pkg::CFG_DATA_W-1:0] cfg_data
);

  import rc5_pkg::*;

  localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
  localparam int STAGES      = 2 * ROUNDS + 1;
  localparam int KEY_WORDS   = (MAX_KEY_BYTES + 3) / 4;
  localparam int TW          = $clog2(TABLE_WORDS);
  localparam int MIX_STEPS   = 3 * TABLE_WORDS;
  localparam int MIX_W       = $clog2(MIX_STEPS);
  localparam int WI_W        = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int CNT_W       = $clog2(KEY_WORDS + 1);

  // key schedule sequencer
  localparam logic [1:0] ST_FILL  = 2'd0;
  localparam logic [1:0] ST_MIX_A = 2'd1;
  localparam logic [1:0] ST_MIX_B = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  logic [1:0]           state;
  logic [63:0]          key_low;
  logic [63:0]          key_high;
  logic [KEY_LEN_W-1:0] key_length;

  logic [TW-1:0]        fill_cnt;
  word_t                fill_val;
  logic [MIX_W-1:0]     mix_cnt;
  word_t                mix_a;
  word_t                mix_b;
  word_t                key_word [KEY_WORDS];
  logic [WI_W-1:0]      wi;
  logic [CNT_W-1:0]     key_count;

  // round key table, kept as a circular shift line: head at entry 0
  word_t                rkey [TABLE_WORDS];
  logic                 rkey_shift;
  word_t                rkey_in;

  // key words and key-word count derived from the registers
  logic [KEY_LEN_W-1:0] len_used;
  logic [127:0]         key_all;
  word_t                key_word_init [KEY_WORDS];
  logic [KEY_LEN_W:0]   count_wide;
  logic [CNT_W-1:0]     count_init;

  word_t                a_new;
  word_t                b_sum;
  word_t                b_new;
  logic [CNT_W-1:0]     wi_inc;
  logic                 cfg_hit;

  always_comb begin
    len_used = (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ?
               KEY_LEN_W'(MAX_KEY_BYTES) : key_length;
    key_all  = {key_high, key_low};
    for (int w = 0; w < KEY_WORDS; w++) begin
      for (int j = 0; j < 4; j++) begin
        if (KEY_LEN_W'(4 * w + j) < len_used) begin
          key_word_init[w][8*j +: 8] = key_all[8*(4*w+j) +: 8];
        end else begin
          key_word_init[w][8*j +: 8] = 8'h00;
        end
      end
    end
    count_wide = ({1'b0, len_used} + (KEY_LEN_W+1)'(3)) >> 2;
    // empty key: one zero key word is mixed
    count_init = (len_used == '0) ? CNT_W'(1) : count_wide[CNT_W-1:0];
  end

  always_comb begin
    a_new  = rotl(rkey[0] + mix_a + mix_b, KEY_ROT);
    b_sum  = mix_a + mix_b;
    b_new  = rotl(key_word[wi] + b_sum, b_sum[4:0]);
    wi_inc = CNT_W'(wi) + CNT_W'(1);
  end

  assign rkey_shift = (state == ST_FILL) || (state == ST_MIX_A);
  assign rkey_in    = (state == ST_FILL) ? fill_val : a_new;

  always_comb begin
    unique case (cfg_index)
      REG_KEY_LOW, REG_KEY_HIGH, REG_KEY_LEN: cfg_hit = cfg_we;
      default:                                cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      key_low    <= '0;
      key_high   <= '0;
      key_length <= KEY_LEN_W'(16);
      fill_cnt   <= '0;
      fill_val   <= MAGIC_P;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low    <= cfg_data;
        REG_KEY_HIGH: key_high   <= cfg_data;
        default:      key_length <= cfg_data[KEY_LEN_W-1:0];
      endcase
      state    <= ST_FILL;
      fill_cnt <= '0;
      fill_val <= MAGIC_P;
    end else begin
      unique case (state)
        ST_FILL: begin
          fill_val <= fill_val + MAGIC_Q;
          if (fill_cnt == TW'(TABLE_WORDS - 1)) begin
            state <= ST_MIX_A;
          end else begin
            fill_cnt <= fill_cnt + TW'(1);
          end
        end
        ST_MIX_A: begin
          state <= ST_MIX_B;
        end
        ST_MIX_B: begin
          if (mix_cnt == MIX_W'(MIX_STEPS - 1)) begin
            state <= ST_RUN;
          end else begin
            state <= ST_MIX_A;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // mixing datapath: A half in ST_MIX_A, B half (variable rotate) in ST_MIX_B after it
  always_ff @(posedge clk) begin
    if (state == ST_FILL) begin
      mix_cnt   <= '0;
      mix_a     <= '0;
      mix_b     <= '0;
      wi        <= '0;
      key_word  <= key_word_init;
      key_count <= count_init;
    end else if (state == ST_MIX_A) begin
      mix_a <= a_new;
    end else if (state == ST_MIX_B) begin
      mix_b        <= b_new;
      key_word[wi] <= b_new;
      wi           <= (wi_inc >= key_count) ? '0 : wi_inc[WI_W-1:0];
      mix_cnt      <= mix_cnt + MIX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rkey_shift) begin
      for (int i = 0; i < TABLE_WORDS - 1; i++) begin
        rkey[i] <= rkey[i+1];
      end
      rkey[TABLE_WORDS-1] <= rkey_in;
    end
  end

  // encryption pipeline: stage 0 adds the whitening keys, then one stage
  // per half round
  logic               pv [STAGES];
  word_t              pa [STAGES];
  word_t              pb [STAGES];
  word_t              na [STAGES];
  word_t              nb [STAGES];
  logic               adv;
  logic               s_fire;

  // output buffer
  logic [1:0]         ob_cnt;
  logic [63:0]        ob0;
  logic [63:0]        ob1;
  logic               ob_push;
  logic               ob_pop;

  assign adv      = (ob_cnt != 2'd2);
  assign s_tready = (state == ST_RUN) && adv;
  assign s_fire   = s_tvalid && s_tready;

  always_comb begin
    na[0] = s_tdata[31:0]  + rkey[0];
    nb[0] = s_tdata[63:32] + rkey[1];
    for (int j = 1; j < STAGES; j++) begin
      if (j % 2 == 1) begin
        na[j] = rotl(pa[j-1] ^ pb[j-1], pb[j-1][4:0]) + rkey[j+1];
        nb[j] = pb[j-1];
      end else begin
        na[j] = pa[j-1];
        nb[j] = rotl(pb[j-1] ^ pa[j-1], pa[j-1][4:0]) + rkey[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < STAGES; j++) begin
        pv[j] <= 1'b0;
      end
    end else if (adv) begin
      pv[0] <= s_fire;
      for (int j = 1; j < STAGES; j++) begin
        pv[j] <= pv[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < STAGES; j++) begin
        pa[j] <= na[j];
        pb[j] <= nb[j];
      end
    end
  end

  // two-entry buffer: ob0 is the head shown on m_tdata
  assign ob_push  = adv && pv[STAGES-1];
  assign ob_pop   = m_tvalid && m_tready;
  assign m_tvalid = (ob_cnt != 2'd0);
  assign m_tdata  = ob0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= 2'd0;
    end else begin
      ob_cnt <= ob_cnt + 2'(ob_push) - 2'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push && ((ob_cnt == 2'd0) || ((ob_cnt == 2'd1) && ob_pop))) begin
      ob0 <= {pb[STAGES-1], pa[STAGES-1]};
    end else if (ob_pop && (ob_cnt == 2'd2)) begin
      ob0 <= ob1;
    end
    if (ob_push && (ob_cnt == 2'd1) && !ob_pop) begin
      ob1 <= {pb[STAGES-1], pa[STAGES-1]};
    end
  end

endmodule
